// File: rtl/clr_pkg.sv
// clr_pkg: shared types, widths and codes of the clipped line rasterizer
`default_nettype none

package clr_pkg;

    localparam int COORD_BITS = 16;
    localparam int DELTA_BITS = COORD_BITS + 1;
    localparam int ERR_BITS   = COORD_BITS + 2;
    localparam int DIM_BITS   = 11;
    localparam int CMP_BITS   = (COORD_BITS > DIM_BITS) ? COORD_BITS : DIM_BITS;
    localparam int CFG_IDX_BITS = 2;

    localparam logic [CFG_IDX_BITS-1:0] REG_LAYER_WIDTH  = CFG_IDX_BITS'(0);
    localparam logic [CFG_IDX_BITS-1:0] REG_LAYER_HEIGHT = CFG_IDX_BITS'(1);

    typedef enum logic [0:0] {
        CMD_START = 1'b0,
        CMD_STEP  = 1'b1
    } cmd_t;

    typedef struct packed {
        logic                         active;
        logic                         swapped;
        logic signed [COORD_BITS-1:0] major_pos;
        logic signed [COORD_BITS-1:0] major_end;
        logic signed [COORD_BITS-1:0] minor_pos;
        logic                         minor_down;
        logic [DELTA_BITS-1:0]        major_delta;
        logic [DELTA_BITS-1:0]        minor_delta;
        logic signed [ERR_BITS-1:0]   error_term;
    } line_state_t;

    typedef struct packed {
        logic                         pixel_valid;
        logic signed [COORD_BITS-1:0] pixel_x;
        logic signed [COORD_BITS-1:0] pixel_y;
        logic                         inside_layer;
        logic                         last_pixel;
    } pixel_t;

endpackage

`default_nettype wire

// File: rtl/clr_setup.sv
// clr_setup: turns two endpoints into the initial stepping state of a line
`default_nettype none

module clr_setup import clr_pkg::*; (
    input  wire logic signed [COORD_BITS-1:0] start_x,
    input  wire logic signed [COORD_BITS-1:0] start_y,
    input  wire logic signed [COORD_BITS-1:0] end_x,
    input  wire logic signed [COORD_BITS-1:0] end_y,
    output line_state_t                       line
);

    logic signed [DELTA_BITS-1:0] dx;
    logic signed [DELTA_BITS-1:0] dy;
    logic [DELTA_BITS-1:0]        adx;
    logic [DELTA_BITS-1:0]        ady;
    logic                         steep;
    logic signed [DELTA_BITS-1:0] d_maj;
    logic signed [DELTA_BITS-1:0] d_min;
    logic signed [COORD_BITS-1:0] a_maj;
    logic signed [COORD_BITS-1:0] b_maj;
    logic signed [COORD_BITS-1:0] a_min;
    logic signed [COORD_BITS-1:0] b_min;
    logic                         flip;
    logic [DELTA_BITS-1:0]        maj_delta;

    always_comb begin
        dx  = DELTA_BITS'(end_x) - DELTA_BITS'(start_x);
        dy  = DELTA_BITS'(end_y) - DELTA_BITS'(start_y);
        adx = dx[DELTA_BITS-1] ? DELTA_BITS'(-dx) : DELTA_BITS'(dx);
        ady = dy[DELTA_BITS-1] ? DELTA_BITS'(-dy) : DELTA_BITS'(dy);
        steep = ady > adx;

        d_maj = steep ? dy : dx;
        d_min = steep ? dx : dy;
        a_maj = steep ? start_y : start_x;
        b_maj = steep ? end_y : end_x;
        a_min = steep ? start_x : start_y;
        b_min = steep ? end_x : end_y;
        maj_delta = steep ? ady : adx;

        // endpoints are walked so that the major coordinate rises
        flip = d_maj[DELTA_BITS-1];

        line.active      = 1'b1;
        line.swapped     = steep;
        line.major_pos   = flip ? b_maj : a_maj;
        line.major_end   = flip ? a_maj : b_maj;
        line.minor_pos   = flip ? b_min : a_min;
        line.major_delta = maj_delta;
        line.minor_delta = steep ? adx : ady;
        line.minor_down  = flip ? !d_min[DELTA_BITS-1]
                                : (d_min[DELTA_BITS-1] || (d_min == '0));
        line.error_term  = ERR_BITS'(maj_delta >> 1);
    end

endmodule

`default_nettype wire

// File: rtl/clr_step.sv
// clr_step: gives the current pixel with its clip flag and advances the line
`default_nettype none

module clr_step import clr_pkg::*; (
    input  wire line_state_t         line,
    input  wire logic [DIM_BITS-1:0] layer_width,
    input  wire logic [DIM_BITS-1:0] layer_height,
    output pixel_t                   pixel,
    output line_state_t              line_next
);

    logic signed [COORD_BITS-1:0] px;
    logic signed [COORD_BITS-1:0] py;
    logic                         last;
    logic                         x_in;
    logic                         y_in;
    logic signed [ERR_BITS-1:0]   err_sub;

    always_comb begin
        px   = line.swapped ? line.minor_pos : line.major_pos;
        py   = line.swapped ? line.major_pos : line.minor_pos;
        last = line.major_pos >= line.major_end;

        x_in = !px[COORD_BITS-1] &&
               (CMP_BITS'($unsigned(px)) < CMP_BITS'(layer_width));
        y_in = !py[COORD_BITS-1] &&
               (CMP_BITS'($unsigned(py)) < CMP_BITS'(layer_height));

        // idle step gives an all-zero result
        pixel.pixel_valid  = line.active;
        pixel.pixel_x      = line.active ? px : '0;
        pixel.pixel_y      = line.active ? py : '0;
        pixel.inside_layer = line.active && x_in && y_in;
        pixel.last_pixel   = line.active && last;

        err_sub   = line.error_term - ERR_BITS'(line.minor_delta);
        line_next = line;
        if (line.active) begin
            if (last) begin
                line_next.active = 1'b0;
            end else begin
                line_next.major_pos = line.major_pos + COORD_BITS'(1);
                if (err_sub[ERR_BITS-1]) begin
                    line_next.error_term = err_sub + ERR_BITS'(line.major_delta);
                    line_next.minor_pos  = line.minor_down
                                         ? line.minor_pos - COORD_BITS'(1)
                                         : line.minor_pos + COORD_BITS'(1);
                end else begin
                    line_next.error_term = err_sub;
                end
            end
        end
    end

endmodule

`default_nettype wire

// File: rtl/clipped_line_rasterizer_top.sv
// clipped_line_rasterizer_top: bresenham line rasterizer with layer clipping
//
//   channel   direction  handshake          payload
//   s_        in         s_valid / s_ready  s_cmd, s_start_x/y, s_end_x/y
//   m_        out        m_valid / m_ready  m_pixel_valid, m_pixel_x/y,
//                                           m_inside_layer, m_last_pixel
//   cfg_      in         cfg_we             cfg_index, cfg_data
//
// one command per clock while no step waits on a stalled result: a transfer
// lands in the input register, then updates the line state and, for a step,
// loads the result register when it fires; a start gives no result.
// a stalled result holds the result register, and the input register then
// holds a step behind it; starts still drain while the output stalls.
// synchronous active-low reset clears the line, the layer size and both stages.
`default_nettype none

module clipped_line_rasterizer_top import clr_pkg::*; (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         cfg_we,
    input  wire logic [CFG_IDX_BITS-1:0]      cfg_index,
    input  wire logic [DIM_BITS-1:0]          cfg_data,
    input  wire logic                         s_valid,
    output      logic                         s_ready,
    input  wire logic                         s_cmd,
    input  wire logic signed [COORD_BITS-1:0] s_start_x,
    input  wire logic signed [COORD_BITS-1:0] s_start_y,
    input  wire logic signed [COORD_BITS-1:0] s_end_x,
    input  wire logic signed [COORD_BITS-1:0] s_end_y,
    output      logic                         m_valid,
    input  wire logic                         m_ready,
    output      logic                         m_pixel_valid,
    output      logic signed [COORD_BITS-1:0] m_pixel_x,
    output      logic signed [COORD_BITS-1:0] m_pixel_y,
    output      logic                         m_inside_layer,
    output      logic                         m_last_pixel
);

    logic                         in_valid_reg, in_valid_next;
    cmd_t                         in_cmd_reg;
    logic signed [COORD_BITS-1:0] in_sx_reg, in_sy_reg, in_ex_reg, in_ey_reg;
    logic [DIM_BITS-1:0]          width_reg, width_next;
    logic [DIM_BITS-1:0]          height_reg, height_next;
    line_state_t                  line_reg, line_next;
    logic                         out_valid_reg, out_valid_next;
    pixel_t                       out_reg, out_next;

    line_state_t setup_line;
    line_state_t step_line;
    pixel_t      step_pixel;
    logic        is_step;
    logic        fire;
    logic        in_take;

    clr_setup u_setup (
        .start_x (in_sx_reg),
        .start_y (in_sy_reg),
        .end_x   (in_ex_reg),
        .end_y   (in_ey_reg),
        .line    (setup_line)
    );

    clr_step u_step (
        .line         (line_reg),
        .layer_width  (width_reg),
        .layer_height (height_reg),
        .pixel        (step_pixel),
        .line_next    (step_line)
    );

    // a start needs no result slot, a step needs a free or draining one
    assign is_step = (in_cmd_reg == CMD_STEP);
    assign fire    = in_valid_reg && (!is_step || !out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || fire;
    assign in_take = s_valid && s_ready;

    always_comb begin
        in_valid_next  = in_take ? 1'b1 : (fire ? 1'b0 : in_valid_reg);
        width_next     = width_reg;
        height_next    = height_reg;
        line_next      = line_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;

        if (cfg_we) begin
            case (cfg_index)
                REG_LAYER_WIDTH:  width_next  = cfg_data;
                REG_LAYER_HEIGHT: height_next = cfg_data;
                default: ;
            endcase
        end

        if (out_valid_reg && m_ready) begin
            out_valid_next = 1'b0;
        end
        if (fire) begin
            if (is_step) begin
                line_next      = step_line;
                out_valid_next = 1'b1;
                out_next       = step_pixel;
            end else begin
                line_next = setup_line;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            width_reg     <= '0;
            height_reg    <= '0;
            line_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            width_reg     <= width_next;
            height_reg    <= height_next;
            line_reg      <= line_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_take) begin
            in_cmd_reg <= cmd_t'(s_cmd);
            in_sx_reg  <= s_start_x;
            in_sy_reg  <= s_start_y;
            in_ex_reg  <= s_end_x;
            in_ey_reg  <= s_end_y;
        end
        out_reg <= out_next;
    end

    assign m_valid        = out_valid_reg;
    assign m_pixel_valid  = out_reg.pixel_valid;
    assign m_pixel_x      = out_reg.pixel_x;
    assign m_pixel_y      = out_reg.pixel_y;
    assign m_inside_layer = out_reg.inside_layer;
    assign m_last_pixel   = out_reg.last_pixel;

    a_idle_result_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_pixel_valid) |->
            (m_pixel_x == '0 && m_pixel_y == '0 && !m_inside_layer && !m_last_pixel))
        else $error("idle step result carries non-zero fields");

    a_inside_non_negative: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_inside_layer) |->
            (!m_pixel_x[COORD_BITS-1] && !m_pixel_y[COORD_BITS-1] && m_pixel_valid))
        else $error("pixel flagged inside the layer at a negative coordinate");

    a_last_ends_line: assert property (@(posedge aclk) disable iff (!aresetn)
        (fire && is_step && step_pixel.last_pixel) |=> !line_reg.active)
        else $error("line still active after its last pixel");

    a_start_no_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (fire && !is_step && !(out_valid_reg && m_ready)) |=>
            (out_valid_reg == $past(out_valid_reg)))
        else $error("start command changed the result register");

endmodule

`default_nettype wire

// File: tb/tb_raster_check_pkg.sv
// tb_raster_check_pkg: line rasterizer predictor and pixel scoreboard
package tb_raster_check_pkg;
    import clr_pkg::*;

    typedef logic signed [COORD_BITS-1:0] coord_t;

    class raster_scoreboard;
        logic [DIM_BITS-1:0]        layer_w = '0;
        logic [DIM_BITS-1:0]        layer_h = '0;
        logic                       line_on = 1'b0;
        logic                       swapped = 1'b0;
        logic                       minor_down = 1'b0;
        coord_t                     major_pos = '0;
        coord_t                     major_end = '0;
        coord_t                     minor_pos = '0;
        logic [DELTA_BITS-1:0]      major_delta = '0;
        logic [DELTA_BITS-1:0]      minor_delta = '0;
        logic signed [ERR_BITS-1:0] error_term = '0;
        pixel_t                     expected_pixels[$];
        int                         fail_count = 0;

        static function int magnitude(int v);
            return (v < 0) ? -v : v;
        endfunction

        function void write_register(logic [CFG_IDX_BITS-1:0] idx, logic [DIM_BITS-1:0] val);
            if (idx == REG_LAYER_WIDTH) begin
                layer_w = val;
            end else if (idx == REG_LAYER_HEIGHT) begin
                layer_h = val;
            end
        endfunction

        function int pending();
            return expected_pixels.size();
        endfunction

        // called on each input transfer; a step queues the pixel it should produce
        function void note_command(cmd_t c, coord_t ax, coord_t ay, coord_t bx, coord_t by);
            int     x0, y0, x1, y1, t, px, py, err;
            logic   steep;
            pixel_t pix;
            if (c == CMD_START) begin
                x0 = ax;
                y0 = ay;
                x1 = bx;
                y1 = by;
                steep = magnitude(y1 - y0) > magnitude(x1 - x0);
                if (steep) begin
                    t = x0; x0 = y0; y0 = t;
                    t = x1; x1 = y1; y1 = t;
                end
                if (x0 > x1) begin
                    t = x0; x0 = x1; x1 = t;
                    t = y0; y0 = y1; y1 = t;
                end
                swapped     = steep;
                major_pos   = coord_t'(x0);
                major_end   = coord_t'(x1);
                minor_pos   = coord_t'(y0);
                major_delta = DELTA_BITS'(x1 - x0);
                minor_delta = DELTA_BITS'(magnitude(y1 - y0));
                minor_down  = !(y0 < y1);
                error_term  = ERR_BITS'((x1 - x0) / 2);
                line_on     = 1'b1;
            end else begin
                pix = '0;
                if (line_on) begin
                    px = swapped ? minor_pos : major_pos;
                    py = swapped ? major_pos : minor_pos;
                    pix.pixel_valid  = 1'b1;
                    pix.pixel_x      = coord_t'(px);
                    pix.pixel_y      = coord_t'(py);
                    pix.inside_layer = px >= 0 && py >= 0 &&
                                       px < int'(layer_w) && py < int'(layer_h);
                    pix.last_pixel   = major_pos >= major_end;
                    if (pix.last_pixel) begin
                        line_on = 1'b0;
                    end else begin
                        err = int'(error_term) - int'(minor_delta);
                        if (err < 0) begin
                            err += int'(major_delta);
                            minor_pos = coord_t'(int'(minor_pos) + (minor_down ? -1 : 1));
                        end
                        error_term = ERR_BITS'(err);
                        major_pos  = coord_t'(int'(major_pos) + 1);
                    end
                end
                expected_pixels.push_back(pix);
            end
        endfunction

        function void compare_field(string name, logic signed [COORD_BITS-1:0] want,
                                    logic signed [COORD_BITS-1:0] got);
            if (got !== want) begin
                $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, want, got);
                fail_count++;
            end
        endfunction

        function void check_pixel(pixel_t got);
            pixel_t want;
            if (expected_pixels.size() == 0) begin
                $display("%0t: pixel transfer with none expected: x=%0d y=%0d",
                         $time, got.pixel_x, got.pixel_y);
                fail_count++;
            end else begin
                want = expected_pixels.pop_front();
                compare_field("pixel_valid", want.pixel_valid, got.pixel_valid);
                compare_field("pixel_x", want.pixel_x, got.pixel_x);
                compare_field("pixel_y", want.pixel_y, got.pixel_y);
                compare_field("inside_layer", want.inside_layer, got.inside_layer);
                compare_field("last_pixel", want.last_pixel, got.last_pixel);
            end
        endfunction
    endclass

endpackage

// File: tb/tb_clipped_line_rasterizer_top.sv
// tb_clipped_line_rasterizer_top: randomised line and step traffic checked against a predictor
module tb_clipped_line_rasterizer_top;
    timeunit 1ns;
    timeprecision 1ps;

    import clr_pkg::*;
    import tb_raster_check_pkg::*;

    localparam logic [CFG_IDX_BITS-1:0] REG_SPARE_A = CFG_IDX_BITS'(2);
    localparam logic [CFG_IDX_BITS-1:0] REG_SPARE_B = CFG_IDX_BITS'(3);
    localparam int DIM_MAX         = 2**DIM_BITS - 1;
    localparam int COORD_MAX       = 2**(COORD_BITS-1) - 1;
    localparam int COORD_MIN       = -COORD_MAX - 1;
    localparam int SPAN            = 24;
    localparam int LONG_LINE       = 64;
    localparam int ITEMS_PER_PHASE = 200;
    localparam int HOLD_OFF_CYCLES = 80;
    localparam int SETTLE_CYCLES   = 4;
    localparam int TAIL_CYCLES     = 8;
    localparam int STALL_LIMIT     = 5000;

    logic                    aclk = 1'b0;
    logic                    aresetn = 1'b0;
    logic                    cfg_we = 1'b0;
    logic [CFG_IDX_BITS-1:0] cfg_index = '0;
    logic [DIM_BITS-1:0]     cfg_data = '0;
    logic                    s_valid = 1'b0;
    logic                    s_ready;
    logic                    s_cmd = CMD_START;
    coord_t                  s_start_x = '0;
    coord_t                  s_start_y = '0;
    coord_t                  s_end_x = '0;
    coord_t                  s_end_y = '0;
    logic                    m_valid;
    logic                    m_ready = 1'b0;
    logic                    m_pixel_valid;
    coord_t                  m_pixel_x;
    coord_t                  m_pixel_y;
    logic                    m_inside_layer;
    logic                    m_last_pixel;

    raster_scoreboard layer_sb = new;
    int src_idle_pct  = 29;
    int sink_idle_pct = 75;
    int hold_left     = 0;
    int items_sent    = 0;
    int quiet_cycles  = 0;

    clipped_line_rasterizer_top DUT (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_cmd          (s_cmd),
        .s_start_x      (s_start_x),
        .s_start_y      (s_start_y),
        .s_end_x        (s_end_x),
        .s_end_y        (s_end_y),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_pixel_valid  (m_pixel_valid),
        .m_pixel_x      (m_pixel_x),
        .m_pixel_y      (m_pixel_y),
        .m_inside_layer (m_inside_layer),
        .m_last_pixel   (m_last_pixel)
    );

    always #5 aclk = ~aclk;

    task automatic send_item(cmd_t c, coord_t ax, coord_t ay, coord_t bx, coord_t by);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_cmd     <= c;
        s_start_x <= ax;
        s_start_y <= ay;
        s_end_x   <= bx;
        s_end_y   <= by;
        do @(posedge aclk); while (!s_ready);
        layer_sb.note_command(c, ax, ay, bx, by);
        items_sent++;
    endtask

    // start a line and advance it; coordinates on a step are don't-care, so randomise them
    task automatic draw(int ax, int ay, int bx, int by, int nsteps);
        send_item(CMD_START, coord_t'(ax), coord_t'(ay), coord_t'(bx), coord_t'(by));
        repeat (nsteps) begin
            send_item(CMD_STEP, coord_t'($urandom), coord_t'($urandom),
                      coord_t'($urandom), coord_t'($urandom));
        end
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (layer_sb.pending() != 0) @(posedge aclk);
        // a trailing start leaves no pixel to wait for but may still be in flight
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic set_layer(logic [DIM_BITS-1:0] w, logic [DIM_BITS-1:0] h);
        logic [CFG_IDX_BITS-1:0] spare_idx;
        logic [DIM_BITS-1:0]     spare_val;
        spare_idx = $urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B;
        spare_val = DIM_BITS'($urandom);
        cfg_we    <= 1'b1;
        cfg_index <= REG_LAYER_WIDTH;
        cfg_data  <= w;
        @(posedge aclk);
        cfg_index <= REG_LAYER_HEIGHT;
        cfg_data  <= h;
        @(posedge aclk);
        // unused index, must leave the layer size alone
        cfg_index <= spare_idx;
        cfg_data  <= spare_val;
        @(posedge aclk);
        cfg_we <= 1'b0;
        layer_sb.write_register(REG_LAYER_WIDTH, w);
        layer_sb.write_register(REG_LAYER_HEIGHT, h);
        layer_sb.write_register(spare_idx, spare_val);
    endtask

    function automatic int edge_coord(bit high);
        return high ? COORD_MAX - int'($urandom_range(0, 12))
                    : COORD_MIN + int'($urandom_range(0, 12));
    endfunction

    task automatic random_line();
        int kind, ax, ay, bx, by, pixels, nsteps;
        bit hx, hy;
        kind = $urandom_range(0, 99);
        hx = $urandom_range(0, 1);
        hy = $urandom_range(0, 1);
        if (kind < 10) begin
            ax = coord_t'($urandom);
            ay = coord_t'($urandom);
            bx = coord_t'($urandom);
            by = coord_t'($urandom);
        end else if (kind < 20) begin
            ax = edge_coord(hx);
            ay = edge_coord(hy);
            bx = edge_coord(hx);
            by = edge_coord(hy);
        end else begin
            ax = int'($urandom_range(0, SPAN)) - 4;
            ay = int'($urandom_range(0, SPAN)) - 4;
            bx = int'($urandom_range(0, SPAN)) - 4;
            by = int'($urandom_range(0, SPAN)) - 4;
        end
        pixels = raster_scoreboard::magnitude(bx - ax);
        if (raster_scoreboard::magnitude(by - ay) > pixels) begin
            pixels = raster_scoreboard::magnitude(by - ay);
        end
        pixels++;
        if (pixels > LONG_LINE) begin
            nsteps = $urandom_range(1, 8);
        end else begin
            case ($urandom_range(0, 9))
                0: nsteps = $urandom_range(0, pixels - 1);
                1: nsteps = pixels + $urandom_range(1, 2);
                default: nsteps = pixels;
            endcase
        end
        draw(ax, ay, bx, by, nsteps);
    endtask

    // result side: check each transfer, then pick the next ready level
    always @(posedge aclk) begin : pixel_sink
        pixel_t got;
        if (aresetn && m_valid && m_ready) begin
            got.pixel_valid  = m_pixel_valid;
            got.pixel_x      = m_pixel_x;
            got.pixel_y      = m_pixel_y;
            got.inside_layer = m_inside_layer;
            got.last_pixel   = m_last_pixel;
            layer_sb.check_pixel(got);
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= sink_idle_pct);
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin : stimulus
        int target;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        set_layer(DIM_BITS'(16), DIM_BITS'(12));

        send_item(CMD_STEP, '0, '0, '0, '0);       // no line yet
        draw(5, 5, 5, 5, 2);                        // single point, then a step while idle
        draw(3, 14, 1, 9, 6);                       // steep, reversed, past the bottom edge
        draw(15, 0, 17, -2, 4);                     // diagonal moving up, past the right edge
        draw(COORD_MIN, COORD_MAX, COORD_MAX, COORD_MIN, 2);
        draw(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, 2);  // replaces the active line
        drain();
        set_layer('0, '0);
        draw(0, 0, 1, 0, 2);

        for (int phase = 0; phase < 3; phase++) begin
            drain();
            case (phase)
                0: begin
                    src_idle_pct  = 29;
                    sink_idle_pct = 75;
                    set_layer(DIM_BITS'(DIM_MAX), DIM_BITS'(DIM_MAX));
                end
                1: begin
                    src_idle_pct  = 75;
                    sink_idle_pct = 29;
                    set_layer(DIM_BITS'($urandom_range(1, 32)),
                              DIM_BITS'($urandom_range(1, 32)));
                end
                default: begin
                    src_idle_pct  = 0;
                    sink_idle_pct = 0;
                    set_layer(DIM_BITS'(DIM_MAX), DIM_BITS'($urandom_range(1, 32)));
                    // long output stall so the input side backs up
                    hold_left = HOLD_OFF_CYCLES;
                end
            endcase
            target = items_sent + ITEMS_PER_PHASE;
            while (items_sent < target) random_line();
        end

        drain();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (layer_sb.fail_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
